// ===== rtl/fire_heat_field_update_defines.svh =====
// Assertion macros shared by the fire heat field RTL.
`ifndef FIRE_HEAT_FIELD_UPDATE_DEFINES_SVH
`define FIRE_HEAT_FIELD_UPDATE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FHF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fire heat field check failed");

// Consequent must hold in the cycle after the antecedent.
`define FHF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fire heat field check failed");

`endif

// ===== rtl/fhf_pkg.sv =====
// Package with the types and constants of the fire heat field block.
`timescale 1ns / 1ps
package fhf_pkg;

    localparam int FHF_MAX_WIDTH  = 128;
    localparam int FHF_MAX_HEIGHT = 128;
    localparam int DIM_MIN        = 3;

    localparam logic [7:0] FIELD_WIDTH_RESET  = 8'd120;
    localparam logic [7:0] FIELD_HEIGHT_RESET = 8'd80;

    // Configuration register indexes.
    localparam logic [7:0] REG_FIELD_WIDTH  = 8'd0;
    localparam logic [7:0] REG_FIELD_HEIGHT = 8'd1;

    localparam logic [5:0] SEED_BASE  = 6'd32;
    localparam logic [5:0] GREEN_KNEE = 6'd16;
    localparam logic [5:0] BLUE_KNEE  = 6'd44;
    localparam logic [9:0] BLUE_GAIN  = 10'd12;
    localparam logic [9:0] CHAN_MAX   = 10'd255;

    typedef struct packed {
        logic [4:0] seed;
        logic       decay;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [6:0] column;
        logic [6:0] line;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic [7:0] index;
        logic [7:0] value;
    } t_cfg_write;

    // What the update stage needs to know about an item.
    typedef struct packed {
        logic       seed_item;
        logic       interior;
        logic       second_last;
        logic       frame_end;
        logic       decay;
        logic [4:0] seed;
    } t_item_ctl;

    typedef struct packed {
        logic valid;
        logic free;
    } t_s1_status;

endpackage

// ===== rtl/fhf_chan_if.sv =====
// Valid/ready channel interface carrying one payload item.
`timescale 1ns / 1ps
interface fhf_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/fhf_heat_mem.sv =====
// Heat field memory: two registered read ports, one write port, clear sweep after reset.
`timescale 1ns / 1ps
module fhf_heat_mem #(
    parameter int MAX_WIDTH  = fhf_pkg::FHF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fhf_pkg::FHF_MAX_HEIGHT,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT),
    localparam int AW = CW + RW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [5:0]    i_wdata,
    output logic [5:0]    o_rdata_a,
    output logic [5:0]    o_rdata_b,
    output logic          o_clearing
);
    import fhf_pkg::*;

    // Rows have a power-of-two stride so an address is {row, column}.
    localparam int DEPTH = MAX_HEIGHT * (2 ** CW);

    logic [5:0]    mem [DEPTH];
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic [5:0]    r_rdata_a;
    logic [5:0]    r_rdata_b;
    logic          we;
    logic [AW-1:0] waddr;
    logic [5:0]    wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_comb begin
        we    = r_clearing | i_we;
        waddr = r_clearing ? r_clr_addr : i_waddr;
        wdata = r_clearing ? 6'd0 : i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_re) begin
            r_rdata_a <= mem[i_raddr_a];
            r_rdata_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a  = r_rdata_a;
    assign o_rdata_b  = r_rdata_b;
    assign o_clearing = r_clearing;

endmodule

// ===== rtl/fhf_scan.sv =====
// Scan sequencer: configuration, frame counters and read address generation.
`timescale 1ns / 1ps
module fhf_scan #(
    parameter int MAX_WIDTH  = fhf_pkg::FHF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fhf_pkg::FHF_MAX_HEIGHT,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    fhf_chan_if.sink            i_item,
    fhf_chan_if.sink            i_cfg,
    input  logic                i_clearing,
    input  logic                i_s1_free,
    output logic                o_re,
    output logic [CW+RW-1:0]    o_raddr_a,
    output logic [CW+RW-1:0]    o_raddr_b,
    output logic                o_load,
    output fhf_pkg::t_item_ctl  o_ctl,
    output logic [CW-1:0]       o_col,
    output logic [RW-1:0]       o_row
);
    import fhf_pkg::*;

    localparam int WW = CW + 1;
    localparam int HW = RW + 1;

    logic [7:0]    r_field_width, n_field_width;
    logic [7:0]    r_field_height, n_field_height;
    logic          r_seeding, n_seeding;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;
    logic [RW-1:0] h_2;
    logic          last_col;
    logic          bottom;
    logic          second_last;
    logic          interior;
    logic [HW-1:0] y_p1;
    logic [HW-1:0] y_p2;
    logic [HW-1:0] row_a_full;
    logic [RW-1:0] row_a;
    logic [CW-1:0] col_a;
    logic [RW-1:0] row_b;
    logic          accept;
    logic          restart;

    // Effective dimensions are the registers clamped to the legal range.
    always_comb begin
        if (r_field_width < 8'(DIM_MIN)) begin
            eff_w = WW'(DIM_MIN);
        end else if (int'(r_field_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_field_width);
        end
        if (r_field_height < 8'(DIM_MIN)) begin
            eff_h = HW'(DIM_MIN);
        end else if (int'(r_field_height) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_field_height);
        end
        w_last = CW'(eff_w - WW'(1));
        h_last = RW'(eff_h - HW'(1));
        h_2    = RW'(eff_h - HW'(2));
    end

    always_comb begin
        last_col    = (r_col == w_last);
        bottom      = (r_row == h_last);
        second_last = (r_row == h_2);
        interior    = !bottom && (r_col != '0) && !last_col;
        y_p1        = HW'(r_row) + HW'(1);
        y_p2        = HW'(r_row) + HW'(2);

        // Port A runs one cell ahead on the row below. On the last column it
        // fetches the first cell of the next row's lower neighbor row instead.
        row_a_full = last_col ? y_p2 : y_p1;
        row_a      = (row_a_full > HW'(h_last)) ? '0 : row_a_full[RW-1:0];
        col_a      = last_col ? '0 : r_col + CW'(1);

        // Port B fetches one or two rows down for interior cells, else the cell itself.
        if (interior) begin
            row_b = second_last ? y_p1[RW-1:0] : y_p2[RW-1:0];
        end else begin
            row_b = r_row;
        end

        if (r_seeding) begin
            // The seed items prime the window for the first raster row.
            o_raddr_a = {RW'(1), {CW{1'b0}}};
            o_raddr_b = {RW'(1), {CW{1'b0}}};
        end else begin
            o_raddr_a = {row_a, col_a};
            o_raddr_b = {row_b, r_col};
        end
    end

    assign i_item.ready = !i_clearing && i_s1_free;
    assign i_cfg.ready  = 1'b1;
    assign accept       = i_item.valid && i_item.ready;
    assign o_re         = accept;
    assign o_load       = accept;

    always_comb begin
        o_ctl.seed_item   = r_seeding;
        o_ctl.interior    = !r_seeding && interior;
        o_ctl.second_last = second_last;
        o_ctl.frame_end   = !r_seeding && last_col && bottom;
        o_ctl.decay       = i_item.data.decay;
        o_ctl.seed        = i_item.data.seed;
        o_col             = r_col;
        o_row             = r_seeding ? h_last : r_row;
    end

    always_comb begin
        n_seeding      = r_seeding;
        n_col          = r_col;
        n_row          = r_row;
        n_field_width  = r_field_width;
        n_field_height = r_field_height;
        restart        = 1'b0;

        if (accept) begin
            if (r_seeding) begin
                n_row = '0;
                if (last_col) begin
                    n_seeding = 1'b0;
                    n_col     = '0;
                end else begin
                    n_col = r_col + CW'(1);
                end
            end else if (last_col && bottom) begin
                n_seeding = 1'b1;
                n_col     = '0;
                n_row     = '0;
            end else if (last_col) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end

        if (i_cfg.valid) begin
            case (i_cfg.data.index)
                REG_FIELD_WIDTH: begin
                    n_field_width = i_cfg.data.value;
                    restart       = 1'b1;
                end
                REG_FIELD_HEIGHT: begin
                    n_field_height = i_cfg.data.value;
                    restart        = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end

        // A write to either dimension register starts a new frame; the field keeps its contents.
        if (restart) begin
            n_seeding = 1'b1;
            n_col     = '0;
            n_row     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_width  <= FIELD_WIDTH_RESET;
            r_field_height <= FIELD_HEIGHT_RESET;
            r_seeding      <= 1'b1;
            r_col          <= '0;
            r_row          <= '0;
        end else begin
            r_field_width  <= n_field_width;
            r_field_height <= n_field_height;
            r_seeding      <= n_seeding;
            r_col          <= n_col;
            r_row          <= n_row;
        end
    end

endmodule

// ===== rtl/fhf_cell_update.sv =====
// Update stage: row window, cell averaging and cooling, write-back and palette output.
`timescale 1ns / 1ps
module fhf_cell_update #(
    parameter int MAX_WIDTH  = fhf_pkg::FHF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fhf_pkg::FHF_MAX_HEIGHT,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  fhf_pkg::t_item_ctl  i_ctl,
    input  logic [CW-1:0]       i_col,
    input  logic [RW-1:0]       i_row,
    input  logic [5:0]          i_rdata_a,
    input  logic [5:0]          i_rdata_b,
    output logic                o_we,
    output logic [CW+RW-1:0]    o_waddr,
    output logic [5:0]          o_wdata,
    output fhf_pkg::t_s1_status o_status,
    fhf_chan_if.source          o_pixel
);
    import fhf_pkg::*;

    logic          r_v1;
    t_item_ctl     r_ctl;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [5:0]    r_w0;
    logic [5:0]    r_w1;
    logic          r_ov;
    t_out_item     r_out;
    t_out_item     n_out;

    logic          out_free;
    logic          s1_adv;
    logic [5:0]    fourth;
    logic [7:0]    sum;
    logic [5:0]    avg;
    logic [5:0]    cooled;
    logic [5:0]    heat;
    logic [9:0]    red_raw;
    logic [9:0]    green_raw;
    logic [9:0]    blue_raw;

    assign out_free = !r_ov || o_pixel.ready;
    // Seed items leave without a result, so they never wait for the output.
    assign s1_adv   = r_v1 && (r_ctl.seed_item || out_free);

    always_comb begin
        // r_w0 and r_w1 hold the lower-left and lower cells; port A brings the
        // lower-right one. On the second-to-last row the lower cell counts twice.
        fourth = r_ctl.second_last ? r_w1 : i_rdata_b;
        sum    = 8'(r_w0) + 8'(r_w1) + 8'(i_rdata_a) + 8'(fourth);
        avg    = sum[7:2];
        cooled = (avg >= 6'(r_ctl.decay)) ? avg - 6'(r_ctl.decay) : 6'd0;
        heat   = r_ctl.interior ? cooled : i_rdata_b;

        red_raw   = 10'(heat) << 3;
        green_raw = (heat < GREEN_KNEE) ? 10'd0 : 10'(heat - GREEN_KNEE) << 3;
        blue_raw  = (heat < BLUE_KNEE) ? 10'd0 : 10'(heat - BLUE_KNEE) * BLUE_GAIN;

        n_out.red       = (red_raw > CHAN_MAX) ? 8'hFF : red_raw[7:0];
        n_out.green     = (green_raw > CHAN_MAX) ? 8'hFF : green_raw[7:0];
        n_out.blue      = (blue_raw > CHAN_MAX) ? 8'hFF : blue_raw[7:0];
        n_out.column    = 7'(r_col);
        n_out.line      = 7'(r_row);
        n_out.frame_end = r_ctl.frame_end;
    end

    assign o_we      = s1_adv && (r_ctl.seed_item || r_ctl.interior);
    assign o_waddr   = {r_row, r_col};
    assign o_wdata   = r_ctl.seed_item ? SEED_BASE + 6'(r_ctl.seed) : cooled;

    assign o_status.valid = r_v1;
    assign o_status.free  = !r_v1 || s1_adv;

    assign o_pixel.valid = r_ov;
    assign o_pixel.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_load) begin
                r_v1 <= 1'b1;
            end else if (s1_adv) begin
                r_v1 <= 1'b0;
            end
            if (s1_adv && !r_ctl.seed_item) begin
                r_ov <= 1'b1;
            end else if (o_pixel.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ctl <= i_ctl;
            r_col <= i_col;
            r_row <= i_row;
        end
        if (s1_adv) begin
            r_w0 <= r_w1;
            r_w1 <= i_rdata_a;
            if (!r_ctl.seed_item) begin
                r_out <= n_out;
            end
        end
    end

endmodule

// ===== rtl/fire_heat_field_update.sv =====
// Top level of the fire heat field update block.
`timescale 1ns / 1ps
// The block accepts one item per clock unless the pixel output stalls, and
// returns each raster result through the update stage and output registers;
// seed items give no result. The heat memory serves two reads and one write
// per clock: one read runs a cell ahead along the row below into a three-cell
// window, the other fetches the cell one or two rows down or the cell itself.
// After reset a clearing pass zeroes MAX_HEIGHT * 2**ceil(log2(MAX_WIDTH))
// entries (16384 at the defaults), one entry per clock; no item is accepted
// during that pass, while configuration writes are taken. Writing either
// dimension register restarts the frame with its seed phase.
module fire_heat_field_update #(
    parameter int MAX_WIDTH  = fhf_pkg::FHF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fhf_pkg::FHF_MAX_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fhf_chan_if.sink   i_item,
    fhf_chan_if.sink   i_cfg,
    fhf_chan_if.source o_pixel
);
    import fhf_pkg::*;

    `include "fire_heat_field_update_defines.svh"

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int AW = CW + RW;

    logic          clearing;
    logic          re;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [5:0]    rdata_a;
    logic [5:0]    rdata_b;
    logic          we;
    logic [AW-1:0] waddr;
    logic [5:0]    wdata;
    logic          load;
    t_item_ctl     ctl;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    t_s1_status    s1_st;

    fhf_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg      (i_cfg),
        .i_clearing (clearing),
        .i_s1_free  (s1_st.free),
        .o_re       (re),
        .o_raddr_a  (raddr_a),
        .o_raddr_b  (raddr_b),
        .o_load     (load),
        .o_ctl      (ctl),
        .o_col      (col),
        .o_row      (row)
    );

    fhf_heat_mem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_re       (re),
        .i_raddr_a  (raddr_a),
        .i_raddr_b  (raddr_b),
        .i_we       (we),
        .i_waddr    (waddr),
        .i_wdata    (wdata),
        .o_rdata_a  (rdata_a),
        .o_rdata_b  (rdata_b),
        .o_clearing (clearing)
    );

    fhf_cell_update #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_update (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_ctl     (ctl),
        .i_col     (col),
        .i_row     (row),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_status  (s1_st),
        .o_pixel   (o_pixel)
    );

    // No item may enter while the memory is still being cleared.
    `FHF_ASSERT_NOW(a_no_accept_clearing, i_clk, i_rst_n, clearing, !i_item.ready)
    // The access pattern never reads a cell in the cycle it is written.
    `FHF_ASSERT_NOW(a_no_rw_collision, i_clk, i_rst_n, re && we, (waddr != raddr_a) && (waddr != raddr_b))
    // An accepted item always lands in the update stage.
    `FHF_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, i_item.valid && i_item.ready, s1_st.valid)

endmodule

// ===== test/fire_heat_field_update_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the fire heat field update block, with its own model.
module fire_heat_field_update_test;
    import fhf_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int PIPE_LATENCY = 2;
    localparam int DRAIN_CYCLES = PIPE_LATENCY + 4;
    // The clearing pass after reset alone keeps every channel quiet.
    localparam int QUIET_LIMIT  = 80000;
    localparam int MAX_SHOWN    = 10;
    localparam int RANDOM_ITEMS = 120;
    localparam int RED_GAIN     = 8;
    localparam int GREEN_GAIN   = 8;
    localparam int RED_KNEE     = 0;

    // Indexes past the register list, which the block must ignore.
    localparam logic [7:0] REG_SPARE = 8'd2;
    localparam logic [7:0] REG_TOP   = 8'hFF;

    logic i_clk;
    logic i_rst_n;

    fhf_chan_if #(.T(t_in_item))   item_ch ();
    fhf_chan_if #(.T(t_cfg_write)) cfg_ch ();
    fhf_chan_if #(.T(t_out_item))  pixel_ch ();

    fire_heat_field_update dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .i_cfg   (cfg_ch),
        .o_pixel (pixel_ch)
    );

    // Local copy of the block's state.
    logic [5:0]  heat_copy [FHF_MAX_WIDTH * FHF_MAX_HEIGHT];
    bit          seed_phase;
    int unsigned next_col;
    int unsigned next_row;
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;

    t_out_item   pixel_queue [$];

    int unsigned items_sent;
    int unsigned pixels_seen;
    int unsigned frames_seen;
    int unsigned cfg_writes;
    int unsigned pixel_faults;
    int unsigned stall_left;
    int unsigned quiet_cycles;
    bit          idle_on;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_dim(input logic [7:0] v, input int unsigned hi);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function automatic int unsigned heat_at(input int unsigned x, input int unsigned y);
        return y * FHF_MAX_WIDTH + x;
    endfunction

    function automatic logic [7:0] palette(input int unsigned v, input int unsigned knee,
                                           input int unsigned gain);
        int unsigned scaled;
        if (v < knee) return 8'd0;
        scaled = (v - knee) * gain;
        if (scaled > CHAN_MAX) return 8'(CHAN_MAX);
        return 8'(scaled);
    endfunction

    function automatic void apply_register(input logic [7:0] index, input logic [7:0] value);
        if (index == REG_FIELD_WIDTH) width_reg = value;
        else if (index == REG_FIELD_HEIGHT) height_reg = value;
        else return;
        seed_phase = 1'b1;
        next_col   = 0;
        next_row   = 0;
    endfunction

    // Moves the local field one item forward; a raster item yields one pixel.
    function automatic void advance_field(input t_in_item it, output bit emits,
                                          output t_out_item px);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned sum;
        int unsigned v;
        bit          last;
        w = clamp_dim(width_reg, FHF_MAX_WIDTH);
        h = clamp_dim(height_reg, FHF_MAX_HEIGHT);
        x = next_col;
        y = next_row;
        if (x >= w) x = 0;
        if (y >= h) y = 0;
        emits = 1'b0;
        px    = '0;
        if (seed_phase) begin
            heat_copy[heat_at(x, h - 1)] = SEED_BASE + 6'(it.seed);
            if (x + 1 >= w) begin
                seed_phase = 1'b0;
                next_col   = 0;
            end else begin
                next_col = x + 1;
            end
            next_row = 0;
            return;
        end
        if (y + 1 < h && x >= 1 && x + 1 < w) begin
            sum = 32'(heat_copy[heat_at(x - 1, y + 1)]) + 32'(heat_copy[heat_at(x, y + 1)])
                + 32'(heat_copy[heat_at(x + 1, y + 1)]);
            // The second-to-last row counts the cell below twice.
            if (y + 2 < h) sum += 32'(heat_copy[heat_at(x, y + 2)]);
            else sum += 32'(heat_copy[heat_at(x, y + 1)]);
            v = sum / 4;
            v = (v >= 32'(it.decay)) ? v - 32'(it.decay) : 0;
            heat_copy[heat_at(x, y)] = v[5:0];
        end
        v = 32'(heat_copy[heat_at(x, y)]);
        last = (x + 1 >= w) && (y + 1 >= h);
        px.red       = palette(v, RED_KNEE, RED_GAIN);
        px.green     = palette(v, 32'(GREEN_KNEE), GREEN_GAIN);
        px.blue      = palette(v, 32'(BLUE_KNEE), 32'(BLUE_GAIN));
        px.column    = x[6:0];
        px.line      = y[6:0];
        px.frame_end = last;
        emits        = 1'b1;
        if (last) begin
            seed_phase = 1'b1;
            next_col   = 0;
            next_row   = 0;
        end else if (x + 1 >= w) begin
            next_col = 0;
            next_row = y + 1;
        end else begin
            next_col = x + 1;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input t_in_item it);
        bit        emits;
        t_out_item px;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        do @(posedge i_clk); while (!item_ch.ready);
        advance_field(it, emits, px);
        if (emits) pixel_queue.push_back(px);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_fixed(input logic [4:0] seed, input logic decay);
        t_in_item it;
        it.seed  = seed;
        it.decay = decay;
        send_item(it);
    endtask

    task automatic send_random(input int unsigned count);
        t_in_item it;
        repeat (count) begin
            it.seed  = 5'($urandom_range(0, 31));
            it.decay = 1'($urandom_range(0, 1));
            send_item(it);
        end
    endtask

    // Seed items give no pixel, so after the last pixel the bench waits out DRAIN_CYCLES as well.
    task automatic write_register(input logic [7:0] index, input logic [7:0] value);
        t_cfg_write wr;
        item_ch.valid <= 1'b0;
        while (pixel_queue.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        wr.index = index;
        wr.value = value;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= wr;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_register(index, value);
        cfg_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Runs on the reset geometry of 120 by 80 before any register is written.
    task automatic test_reset_geometry();
        send_random(int'(FIELD_WIDTH_RESET) + 4);
    endtask

    task automatic test_edge_values();
        // Height is still at its reset value, so row 0 must not end the frame.
        write_register(REG_FIELD_WIDTH, 8'(DIM_MIN));
        send_fixed(5'd0, 1'b1);
        send_fixed(5'd31, 1'b0);
        send_fixed(5'd31, 1'b1);
        // The cells under row 0 are cold, so a decay here has to stop at zero.
        send_fixed(5'd0, 1'b1);
        send_fixed(5'd0, 1'b1);
        send_fixed(5'd0, 1'b1);
        send_fixed(5'd31, 1'b0);
        send_fixed(5'd31, 1'b1);

        // Hottest seeds drive the palette to its top on the second-to-last row.
        write_register(REG_FIELD_HEIGHT, 8'(DIM_MIN));
        repeat (3) send_fixed(5'd31, 1'b1);
        send_fixed(5'd31, 1'b0);
        send_fixed(5'd31, 1'b0);
        // A write to a spare index must not restart the frame.
        write_register(REG_SPARE, 8'd1);
        send_fixed(5'd0, 1'b1);
        send_fixed(5'd0, 1'b1);
        send_fixed(5'd0, 1'b0);
        send_fixed(5'd0, 1'b1);
        send_fixed(5'd0, 1'b1);
        send_fixed(5'd0, 1'b1);

        // Coldest seeds and full cooling.
        repeat (3) send_fixed(5'd0, 1'b0);
        repeat (4) send_fixed(5'd31, 1'b1);
        write_register(REG_TOP, 8'hFF);
        repeat (5) send_fixed(5'd31, 1'b1);
    endtask

    // Seed phases and the first raster cells at the widest and the tallest geometry,
    // reached through out-of-range writes.
    task automatic test_extreme_dims();
        write_register(REG_FIELD_WIDTH, 8'hFF);
        write_register(REG_FIELD_HEIGHT, 8'd2);
        send_random(FHF_MAX_WIDTH + 4);
        write_register(REG_FIELD_WIDTH, 8'd0);
        write_register(REG_FIELD_HEIGHT, 8'hFF);
        send_random(DIM_MIN + DIM_MIN * 8);
    endtask

    task automatic test_random_frames(input int unsigned count, input bit with_idle);
        int unsigned sent_here;
        int unsigned pick;
        int unsigned which;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        logic [7:0]  wv;
        logic [7:0]  hv;
        sent_here = 0;
        while (sent_here < count) begin
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
                case ($urandom_range(0, 2))
                    0: wv = 8'd128;
                    1: wv = 8'd129;
                    default: wv = 8'hFF;
                endcase
                hv = 8'($urandom_range(0, 4));
            end else if (pick == 1) begin
                wv = 8'($urandom_range(0, 4));
                hv = 8'($urandom_range(128, 255));
            end else begin
                wv = 8'($urandom_range(0, 9));
                hv = 8'($urandom_range(0, 6));
            end
            which = $urandom_range(0, 3);
            if (which != 1) write_register(REG_FIELD_WIDTH, wv);
            if (which != 0) write_register(REG_FIELD_HEIGHT, hv);
            if ($urandom_range(0, 5) == 0)
                write_register(8'($urandom_range(REG_SPARE, REG_TOP)), 8'($urandom));
            w = clamp_dim(width_reg, FHF_MAX_WIDTH);
            h = clamp_dim(height_reg, FHF_MAX_HEIGHT);
            if (pick == 0) begin
                n = w + $urandom_range(1, 2 * w);
            end else if (pick == 1) begin
                n = w + $urandom_range(1, w * h);
            end else begin
                n = (w + w * h) * $urandom_range(1, 3);
                // Some phases stop in the middle of a frame.
                if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
            end
            if (n > count - sent_here) n = count - sent_here;
            idle_on = with_idle && ($urandom_range(0, 5) != 0);
            send_random(n);
            sent_here += n;
        end
    endtask

    task automatic test_quiet_tail();
        test_random_frames(RANDOM_ITEMS / 5, 1'b0);
    endtask

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            pixel_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            pixel_ch.ready <= 1'b0;
        end else begin
            pixel_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_pixels
        t_out_item got;
        t_out_item want;
        if (pixel_ch.valid === 1'b1 && pixel_ch.ready) begin
            got = pixel_ch.data;
            pixels_seen++;
            if (got.frame_end) frames_seen++;
            if (pixel_queue.size() == 0) begin
                pixel_faults++;
                if (pixel_faults <= MAX_SHOWN)
                    $display("Unexpected pixel: col=%0d line=%0d rgb=%0d,%0d,%0d end=%0d",
                             got.column, got.line, got.red, got.green, got.blue,
                             got.frame_end);
            end else begin
                want = pixel_queue.pop_front();
                if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue || got.column !== want.column
                        || got.line !== want.line || got.frame_end !== want.frame_end) begin
                    pixel_faults++;
                    if (pixel_faults <= MAX_SHOWN) begin
                        $display("Pixel mismatch: expected col=%0d line=%0d rgb=%0d,%0d,%0d end=%0d",
                                 want.column, want.line, want.red, want.green, want.blue,
                                 want.frame_end);
                        $display("                     got col=%0d line=%0d rgb=%0d,%0d,%0d end=%0d",
                                 got.column, got.line, got.red, got.green, got.blue,
                                 got.frame_end);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
                    || (pixel_ch.valid && pixel_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog expired after %0d quiet cycles.", QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        for (int i = 0; i < FHF_MAX_WIDTH * FHF_MAX_HEIGHT; i++) heat_copy[i] = '0;
        seed_phase   = 1'b1;
        next_col     = 0;
        next_row     = 0;
        width_reg    = FIELD_WIDTH_RESET;
        height_reg   = FIELD_HEIGHT_RESET;
        items_sent   = 0;
        pixels_seen  = 0;
        frames_seen  = 0;
        cfg_writes   = 0;
        pixel_faults = 0;
        stall_left   = 0;
        idle_on      = 1'b1;
        i_rst_n        <= 1'b0;
        item_ch.valid  <= 1'b0;
        item_ch.data   <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.data    <= '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_geometry();
        test_edge_values();
        test_extreme_dims();
        test_random_frames(RANDOM_ITEMS - RANDOM_ITEMS / 5, 1'b1);
        test_quiet_tail();

        item_ch.valid <= 1'b0;
        while (pixel_queue.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d items and %0d register writes; checked %0d pixels over %0d frames.",
                 items_sent, cfg_writes, pixels_seen, frames_seen);
        $display("Geometries from 3x3 up to 128 wide and 128 tall, clamped writes, %0d faults.",
                 pixel_faults);
        if (pixel_faults == 0 && pixel_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== fire_heat_field_update.f =====
+incdir+rtl
rtl/fhf_pkg.sv
rtl/fhf_chan_if.sv
rtl/fhf_heat_mem.sv
rtl/fhf_scan.sv
rtl/fhf_cell_update.sv
rtl/fire_heat_field_update.sv
test/fire_heat_field_update_test.sv
